// ===== design/bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and tables of the binned feature scorer
// Bin edges, signed bin weights, model thresholds and the stage record that
// travels along the chain of scoring cells.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int MAX_FEATURES = 8;
  localparam int MAX_BINS     = 6;
  localparam int MAX_EDGES    = MAX_BINS - 1;
  localparam int MAX_MODELS   = 4;

  localparam int DEF_FEATURE_COUNT = 8;
  localparam int DEF_BIN_COUNT     = 6;
  localparam int DEF_MODEL_COUNT   = 4;

  localparam int APP_W    = 16;
  localparam int FEAT_W   = 32;
  localparam int MODEL_W  = 2;
  localparam int BIN_W    = 3;
  localparam int WEIGHT_W = 8;
  localparam int ACC_W    = 10;
  localparam int SCORE_W  = 9;
  localparam int THR_W    = 8;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [APP_W-1:0] APP_ID_MAX = 16'd3;

  localparam logic signed [ACC_W-1:0] SCORE_HI = 10'sd255;
  localparam logic signed [ACC_W-1:0] SCORE_LO = -10'sd256;

  typedef enum logic {
    REG_GENERIC_MODEL = 1'b0,
    REG_NONE          = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic                    valid;
    logic [MODEL_W-1:0]      model;
    logic signed [ACC_W-1:0] acc;
  } stage_t;

  localparam logic [FEAT_W-1:0] BIN_EDGE [MAX_FEATURES][MAX_EDGES] = '{
    '{32'd10,   32'd100,  32'd500,   32'd2000,  32'd10000},
    '{32'd10,   32'd100,  32'd500,   32'd2000,  32'd10000},
    '{32'd8,    32'd32,   32'd96,    32'd160,   32'd224},
    '{32'd10,   32'd100,  32'd500,   32'd2000,  32'd10000},
    '{32'd0,    32'd1,    32'd2,     32'd4,     32'd8},
    '{32'd0,    32'd1,    32'd2,     32'd3,     32'd5},
    '{32'd10,   32'd100,  32'd500,   32'd2000,  32'd10000},
    '{32'd4096, 32'd8192, 32'd16384, 32'd24576, 32'd30000}
  };

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_ROM [MAX_MODELS][MAX_FEATURES][MAX_BINS] = '{
    '{
      '{ 8'sd38,  8'sd29,  8'sd18,  8'sd7,  -8'sd9,  -8'sd21},
      '{ 8'sd24,  8'sd18,  8'sd11,  8'sd3,  -8'sd8,  -8'sd17},
      '{-8'sd18, -8'sd7,   8'sd3,   8'sd15,  8'sd26,  8'sd37},
      '{ 8'sd22,  8'sd16,  8'sd9,   8'sd1,  -8'sd9,  -8'sd19},
      '{ 8'sd22,  8'sd13,  8'sd5,  -8'sd5,  -8'sd15, -8'sd25},
      '{ 8'sd19,  8'sd11,  8'sd3,  -8'sd5,  -8'sd14, -8'sd23},
      '{ 8'sd17,  8'sd11,  8'sd5,  -8'sd2,  -8'sd10, -8'sd19},
      '{-8'sd22, -8'sd13, -8'sd4,   8'sd8,   8'sd21,  8'sd34}
    },
    '{
      '{ 8'sd42,  8'sd32,  8'sd20,  8'sd8,  -8'sd8,  -8'sd22},
      '{ 8'sd26,  8'sd20,  8'sd12,  8'sd4,  -8'sd8,  -8'sd18},
      '{-8'sd20, -8'sd8,   8'sd4,   8'sd16,  8'sd28,  8'sd40},
      '{ 8'sd24,  8'sd18,  8'sd10,  8'sd2,  -8'sd8,  -8'sd18},
      '{ 8'sd24,  8'sd14,  8'sd6,  -8'sd4,  -8'sd14, -8'sd26},
      '{ 8'sd20,  8'sd12,  8'sd4,  -8'sd4,  -8'sd12, -8'sd20},
      '{ 8'sd18,  8'sd12,  8'sd6,   8'sd0,  -8'sd8,  -8'sd16},
      '{-8'sd24, -8'sd14, -8'sd4,   8'sd8,   8'sd20,  8'sd32}
    },
    '{
      '{ 8'sd36,  8'sd28,  8'sd18,  8'sd8,  -8'sd6,  -8'sd18},
      '{ 8'sd20,  8'sd16,  8'sd10,  8'sd4,  -8'sd6,  -8'sd14},
      '{-8'sd16, -8'sd6,   8'sd4,   8'sd14,  8'sd24,  8'sd34},
      '{ 8'sd18,  8'sd14,  8'sd8,   8'sd2,  -8'sd8,  -8'sd16},
      '{ 8'sd20,  8'sd12,  8'sd4,  -8'sd4,  -8'sd12, -8'sd22},
      '{ 8'sd18,  8'sd10,  8'sd2,  -8'sd6,  -8'sd14, -8'sd22},
      '{ 8'sd16,  8'sd10,  8'sd4,  -8'sd2,  -8'sd10, -8'sd18},
      '{-8'sd30, -8'sd18, -8'sd6,   8'sd10,  8'sd26,  8'sd42}
    },
    '{
      '{ 8'sd46,  8'sd34,  8'sd20,  8'sd6,  -8'sd12, -8'sd28},
      '{ 8'sd30,  8'sd22,  8'sd12,  8'sd2,  -8'sd10, -8'sd22},
      '{-8'sd22, -8'sd10,  8'sd2,   8'sd16,  8'sd30,  8'sd44},
      '{ 8'sd28,  8'sd20,  8'sd10,  8'sd0,  -8'sd12, -8'sd24},
      '{ 8'sd26,  8'sd16,  8'sd6,  -8'sd6,  -8'sd18, -8'sd30},
      '{ 8'sd22,  8'sd12,  8'sd2,  -8'sd8,  -8'sd18, -8'sd28},
      '{ 8'sd20,  8'sd12,  8'sd4,  -8'sd4,  -8'sd14, -8'sd24},
      '{-8'sd18, -8'sd10, -8'sd2,   8'sd6,   8'sd16,  8'sd26}
    }
  };

  localparam logic [THR_W-1:0] THRESHOLD_ROM [MAX_MODELS] = '{
    8'd96, 8'd94, 8'd100, 8'd88
  };

endpackage

// ===== design/bfs_cell.sv =====
// ----------------------------------------------------------------------------
// bfs_cell: one scoring cell of the chain
// Bins its own feature against the edge row, adds the bin weight of the
// item's model to the running score and hands everything to the next cell.
// ----------------------------------------------------------------------------
module bfs_cell
  import bfs_pkg::*;
#(
  parameter int K             = 0,
  parameter int FEATURE_COUNT = DEF_FEATURE_COUNT,
  parameter int BIN_COUNT     = DEF_BIN_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  stage_t                               stage_in,
  input  logic [FEATURE_COUNT-1:0][FEAT_W-1:0] feat_in,
  output stage_t                               stage_out,
  output logic [FEATURE_COUNT-1:0][FEAT_W-1:0] feat_out
);

  logic [BIN_W-1:0]           bin;
  logic                       stop;
  logic signed [WEIGHT_W-1:0] weight;
  stage_t                     stage_next;

  always_comb begin
    bin  = '0;
    stop = 1'b0;
    for (int b = 0; b < BIN_COUNT - 1; b++) begin
      if (!stop && (feat_in[K] > BIN_EDGE[K][b])) begin
        bin = BIN_W'(b + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign weight = WEIGHT_ROM[stage_in.model][K][bin];

  always_comb begin
    stage_next       = stage_in;
    stage_next.acc   = stage_in.acc + {{(ACC_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_next.valid;
    end
    stage_out.model <= stage_next.model;
    stage_out.acc   <= stage_next.acc;
    feat_out        <= feat_in;
  end

endmodule

// ===== design/binned_feature_scorer.sv =====
// ----------------------------------------------------------------------------
// binned_feature_scorer: binned linear scorecard for reclaim candidates
// Scores an application id and eight features through a chain of cells,
// one cell per feature, and compares the score with the model threshold.
// ----------------------------------------------------------------------------
// Usage:
//   An item is accepted on a rising edge with start high and busy low. busy
//   stays low, so a new item may be started in every cycle.
//   Each item enters the first cell and moves one cell per cycle; each cell
//   bins one feature and adds its weight. A final register saturates the
//   score and forms the threshold compare.
//   The result goes out with done high for exactly one cycle, after the item
//   has passed every cell and the final register. Results leave in the order
//   of acceptance.
//   Throughput is one item per cycle, set by the one-cell-per-cycle chain.
//   The receiver cannot stall; every result is a transfer in its cycle.
//   generic_model_index sits at byte address 0 of the APB port and selects
//   the model for application ids above three. Write it only while idle.
//   Reset clears the pipeline and sets generic_model_index to zero.
// ----------------------------------------------------------------------------
module binned_feature_scorer
  import bfs_pkg::*;
#(
  parameter int FEATURE_COUNT = DEF_FEATURE_COUNT,
  parameter int BIN_COUNT     = DEF_BIN_COUNT,
  parameter int MODEL_COUNT   = DEF_MODEL_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [APP_W-1:0]    app_id,
  input  logic [FEAT_W-1:0]   feature_0,
  input  logic [FEAT_W-1:0]   feature_1,
  input  logic [FEAT_W-1:0]   feature_2,
  input  logic [FEAT_W-1:0]   feature_3,
  input  logic [FEAT_W-1:0]   feature_4,
  input  logic [FEAT_W-1:0]   feature_5,
  input  logic [FEAT_W-1:0]   feature_6,
  input  logic [FEAT_W-1:0]   feature_7,
  output logic                done,
  output logic [SCORE_W-1:0]  score,
  output logic [THR_W-1:0]    model_threshold,
  output logic                passes,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [MODEL_W-1:0]                   generic_model_index;
  reg_sel_t                             reg_sel;
  logic [MAX_FEATURES-1:0][FEAT_W-1:0]  feat_all;
  logic [MODEL_W-1:0]                   model_sel;
  stage_t                               stage_chain [FEATURE_COUNT+1];
  logic [FEATURE_COUNT-1:0][FEAT_W-1:0] feat_chain  [FEATURE_COUNT+1];
  logic signed [ACC_W-1:0]              acc_sat;
  logic [THR_W-1:0]                     thr_next;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  assign reg_sel = reg_sel_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      generic_model_index <= '0;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_GENERIC_MODEL)) begin
      generic_model_index <= pwdata[MODEL_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GENERIC_MODEL: prdata = {{(DATA_W-MODEL_W){1'b0}}, generic_model_index};
      default:           prdata = '0;
    endcase
  end

  assign feat_all = {feature_7, feature_6, feature_5, feature_4,
                     feature_3, feature_2, feature_1, feature_0};

  always_comb begin
    if (app_id > APP_ID_MAX) begin
      model_sel = generic_model_index;
    end else begin
      model_sel = app_id[MODEL_W-1:0];
    end
    if (int'(model_sel) >= MODEL_COUNT) begin
      model_sel = '0;
    end
  end

  always_comb begin
    stage_chain[0].valid = start && !busy;
    stage_chain[0].model = model_sel;
    stage_chain[0].acc   = '0;
  end

  assign feat_chain[0] = feat_all[FEATURE_COUNT-1:0];

  for (genvar k = 0; k < FEATURE_COUNT; k++) begin : g_cell
    bfs_cell #(
      .K             (k),
      .FEATURE_COUNT (FEATURE_COUNT),
      .BIN_COUNT     (BIN_COUNT)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (stage_chain[k]),
      .feat_in   (feat_chain[k]),
      .stage_out (stage_chain[k+1]),
      .feat_out  (feat_chain[k+1])
    );
  end

  always_comb begin
    if (stage_chain[FEATURE_COUNT].acc > SCORE_HI) begin
      acc_sat = SCORE_HI;
    end else if (stage_chain[FEATURE_COUNT].acc < SCORE_LO) begin
      acc_sat = SCORE_LO;
    end else begin
      acc_sat = stage_chain[FEATURE_COUNT].acc;
    end
  end

  assign thr_next = THRESHOLD_ROM[stage_chain[FEATURE_COUNT].model];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_chain[FEATURE_COUNT].valid;
    end
    score           <= acc_sat[SCORE_W-1:0];
    model_threshold <= thr_next;
    passes          <= (acc_sat >= $signed({{(ACC_W-THR_W){1'b0}}, thr_next}));
  end

  // A result comes out only for an item accepted earlier at the head of the chain.
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, FEATURE_COUNT + 1))
    else $error("result without a matching accepted item");

  // Every accepted item yields a result once it has passed the chain and the output register.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(FEATURE_COUNT + 1) done)
    else $error("accepted item produced no result");

  // The pass flag agrees with the delivered score and threshold.
  a_pass_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (passes == ($signed({score[SCORE_W-1], score}) >=
                         $signed({2'b00, model_threshold}))))
    else $error("pass flag inconsistent with score and threshold");

  // A direct model id delivers that model's threshold.
  a_direct_thr: assert property (@(posedge clk) disable iff (rst)
    (done && $past(app_id, FEATURE_COUNT + 1) < APP_W'(MODEL_COUNT)) |->
      (model_threshold == THRESHOLD_ROM[$past(app_id[MODEL_W-1:0], FEATURE_COUNT + 1)]))
    else $error("threshold does not match the directly selected model");

endmodule
